### hdl/cepstral_mean_normalizer_unit_assert.svh
// assertion macros for the cepstral mean normalizer
`ifndef CEPSTRAL_MEAN_NORMALIZER_UNIT_ASSERT_SVH
`define CEPSTRAL_MEAN_NORMALIZER_UNIT_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define CMN_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cmn assertion failed");

// condition holds in the cycle after the trigger
`define CMN_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cmn assertion failed");

`endif

### hdl/cmn_pkg.sv
// shared types and constants of the cepstral mean normalizer
`default_nettype none

package cmn_pkg;

   localparam int MAX_DIM     = 32;
   localparam int MEAN_AW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam int IDX_W    = 5;
   localparam int VALUE_W  = 32;
   localparam int TIME_W   = 16;
   localparam int DIM_W    = 6;
   localparam int CMD_W    = 2;
   localparam int FRAC_W   = 16;
   localparam int ALPHA_W  = 17;
   localparam int COEF_W   = ALPHA_W + 1;
   localparam int PROD_W   = COEF_W + VALUE_W;
   localparam int TDATA_W  = 40;
   localparam int ADDR_W   = 5;
   localparam int CSR_W    = 32;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 17'h10000;
   localparam logic [TIME_W-1:0]  TIME_LIMIT = 16'hFFFF;
   localparam logic [PROD_W-1:0]  ROUND_HALF = PROD_W'(32768);

   localparam logic [DIM_W-1:0]  DIM_RST    = 6'd13;
   localparam logic [DIM_W-1:0]  ENERGY_RST = 6'h3F;
   localparam logic [TIME_W-1:0] TMIN_RST   = 16'd1;
   localparam logic [TIME_W-1:0] TMAX_RST   = 16'd100;
   localparam logic [TIME_W-1:0] START_RST  = 16'd0;

   typedef enum logic [CMD_W-1:0] {
      CMD_UPD_SUB = 2'd0,
      CMD_SUB     = 2'd1,
      CMD_UPD     = 2'd2,
      CMD_NOP     = 2'd3
   } cmn_cmd_type;

   typedef enum logic [2:0] {
      REG_DIM    = 3'd0,
      REG_ENERGY = 3'd1,
      REG_TMIN   = 3'd2,
      REG_TMAX   = 3'd3,
      REG_START  = 3'd4
   } cmn_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DIV,
      ST_MUL_X,
      ST_MUL_M,
      ST_ROUND,
      ST_FIN
   } cmn_state_type;

   // one classified item as it sits in the queue
   typedef struct packed {
      logic                upd;
      logic                emit;
      logic                active;
      logic                last;
      logic [IDX_W-1:0]    idx;
      logic [VALUE_W-1:0]  value;
   } cmn_item_type;

   typedef struct packed {
      logic [TIME_W-1:0] time_min;
      logic [TIME_W-1:0] time_max;
      logic              load_time;
      logic [TIME_W-1:0] start_time;
   } cmn_back_cfg_type;

   typedef struct packed {
      logic              busy;
      logic [TIME_W-1:0] frame_time;
   } cmn_back_status_type;

endpackage

`default_nettype wire

### hdl/cmn_front.sv
// front end: accepts input beats, classifies them and queues them
`default_nettype none

module cmn_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [cmn_pkg::CMD_W-1:0]           cmd,
   input  logic [cmn_pkg::IDX_W-1:0]           idx,
   input  logic [cmn_pkg::VALUE_W-1:0]         value,
   input  logic                                last,
   input  logic [cmn_pkg::DIM_W-1:0]           dim_in_use,
   input  logic [cmn_pkg::DIM_W-1:0]           energy_index,
   output logic                                q_valid,
   output cmn_pkg::cmn_item_type               q_item,
   input  logic                                q_pop
);

   cmn_pkg::cmn_cmd_type  cmd_w;
   cmn_pkg::cmn_item_type item_in;
   logic                  push;
   logic                  is_energy;

   cmn_pkg::cmn_item_type              queue_ff [cmn_pkg::QUEUE_DEPTH];
   logic [cmn_pkg::QUEUE_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [cmn_pkg::QUEUE_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [cmn_pkg::QUEUE_CW-1:0]       count_ff, count_in;

   function automatic logic [cmn_pkg::QUEUE_AW-1:0] ptr_next(
      input logic [cmn_pkg::QUEUE_AW-1:0] ptr);
      if (ptr == cmn_pkg::QUEUE_AW'(cmn_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

   assign cmd_w = cmn_pkg::cmn_cmd_type'(cmd);

   // classification
   always_comb begin
      is_energy      = !energy_index[cmn_pkg::DIM_W-1] &&
                       (energy_index[cmn_pkg::IDX_W-1:0] == idx);
      item_in.upd    = cmd_w inside {cmn_pkg::CMD_UPD_SUB, cmn_pkg::CMD_UPD};
      item_in.emit   = cmd_w inside {cmn_pkg::CMD_UPD_SUB, cmn_pkg::CMD_SUB};
      item_in.active = (cmn_pkg::DIM_W'(idx) < dim_in_use) &&
                       (int'(idx) < cmn_pkg::MAX_DIM) && !is_energy;
      item_in.last   = last;
      item_in.idx    = idx;
      item_in.value  = value;
   end

   assign req_tready = count_ff != cmn_pkg::QUEUE_CW'(cmn_pkg::QUEUE_DEPTH);
   // the unused command is taken and dropped here
   assign push       = req_tvalid && req_tready && (cmd_w != cmn_pkg::CMD_NOP);
   assign q_valid    = count_ff != '0;
   assign q_item     = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = q_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

`default_nettype wire

### hdl/cmn_recip.sv
// serial restoring divider for the weight, one quotient bit per cycle
`default_nettype none

module cmn_recip (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [cmn_pkg::TIME_W-1:0]    divisor,
   output logic                          done,
   output logic [cmn_pkg::ALPHA_W-1:0]   quotient
);

   localparam int STEPS = cmn_pkg::ALPHA_W;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [cmn_pkg::ALPHA_W-1:0]   quo_ff, quo_in;
   logic [cmn_pkg::TIME_W-1:0]    rem_ff, rem_in;
   logic [cmn_pkg::TIME_W-1:0]    div_ff, div_in;
   logic [cmn_pkg::TIME_W:0]      rem_sh;
   logic [cmn_pkg::TIME_W:0]      rem_sub;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[cmn_pkg::ALPHA_W-1]};
      rem_sub = rem_sh - {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         // numerator is one plus half the divisor, for round half up
         busy_in = 1'b1;
         cnt_in  = CNT_W'(STEPS);
         div_in  = divisor;
         rem_in  = '0;
         quo_in  = cmn_pkg::ALPHA_ONE + cmn_pkg::ALPHA_W'(divisor >> 1);
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, div_ff}) begin
            rem_in = rem_sub[cmn_pkg::TIME_W-1:0];
            quo_in = {quo_ff[cmn_pkg::ALPHA_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[cmn_pkg::TIME_W-1:0];
            quo_in = {quo_ff[cmn_pkg::ALPHA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

### hdl/cmn_back.sv
// back end: mean store, weight, multiply-accumulate and result register
`default_nettype none

module cmn_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   input  cmn_pkg::cmn_item_type           q_item,
   output logic                            q_pop,
   input  cmn_pkg::cmn_back_cfg_type       cfg,
   output cmn_pkg::cmn_back_status_type    status,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [cmn_pkg::VALUE_W-1:0]     rsp_value,
   output logic [cmn_pkg::IDX_W-1:0]       rsp_idx,
   output logic                            rsp_last
);

   cmn_pkg::cmn_state_type state_ff, state_in;
   cmn_pkg::cmn_item_type  item_ff;

   logic [cmn_pkg::TIME_W-1:0]  frame_time_ff;
   logic [cmn_pkg::TIME_W-1:0]  clamp_time;

   // control from the sequencer
   logic div_start, mem_rd, mul_x, mul_m, rnd, rd_load, fin_go, fin_stall;

   logic                         div_done;
   logic [cmn_pkg::ALPHA_W-1:0]  alpha;

   logic [cmn_pkg::VALUE_W-1:0]  mean_mem [cmn_pkg::MAX_DIM];
   logic [cmn_pkg::MAX_DIM-1:0]  mean_vld_ff;
   logic [cmn_pkg::VALUE_W-1:0]  mean_rd_ff;
   logic                         mean_rd_vld_ff;
   logic [cmn_pkg::VALUE_W-1:0]  mean_cur;
   logic [cmn_pkg::VALUE_W-1:0]  mean_ff;
   logic [cmn_pkg::MEAN_AW-1:0]  rd_addr, wr_addr;
   logic                         mem_wr;

   logic signed [cmn_pkg::COEF_W-1:0]  coef;
   logic signed [cmn_pkg::VALUE_W-1:0] mdata;
   logic signed [cmn_pkg::PROD_W-1:0]  prod;
   logic signed [cmn_pkg::PROD_W-1:0]  acc_ff;
   logic [cmn_pkg::PROD_W-1:0]         rnd_sum;

   logic [cmn_pkg::VALUE_W:0]    diff;
   logic [cmn_pkg::VALUE_W-1:0]  diff_sat;
   logic [cmn_pkg::VALUE_W-1:0]  result;

   logic                         rsp_tvalid_ff;

   // weight divisor: frame time clamped, zero taken as one
   always_comb begin
      if (frame_time_ff < cfg.time_min) begin
         clamp_time = cfg.time_min;
      end else if (frame_time_ff > cfg.time_max) begin
         clamp_time = cfg.time_max;
      end else begin
         clamp_time = frame_time_ff;
      end
      if (clamp_time == '0) begin
         clamp_time = cmn_pkg::TIME_W'(1);
      end
   end

   cmn_recip u_recip (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (clamp_time),
      .done     (div_done),
      .quotient (alpha)
   );

   // result register can take a beat unless it holds one that is stalled
   assign fin_stall = item_ff.emit && rsp_tvalid_ff && !rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cmn_pkg::ST_IDLE: begin
            if (q_valid) begin
               if (q_item.upd && q_item.active) begin
                  state_in = cmn_pkg::ST_DIV;
               end else if (q_item.active) begin
                  state_in = cmn_pkg::ST_READ;
               end else begin
                  state_in = cmn_pkg::ST_FIN;
               end
            end
         end
         cmn_pkg::ST_READ:  state_in = cmn_pkg::ST_FIN;
         cmn_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = cmn_pkg::ST_MUL_X;
            end
         end
         cmn_pkg::ST_MUL_X: state_in = cmn_pkg::ST_MUL_M;
         cmn_pkg::ST_MUL_M: state_in = cmn_pkg::ST_ROUND;
         cmn_pkg::ST_ROUND: state_in = cmn_pkg::ST_FIN;
         cmn_pkg::ST_FIN: begin
            if (!fin_stall) begin
               state_in = cmn_pkg::ST_IDLE;
            end
         end
         default: state_in = cmn_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      q_pop     = 1'b0;
      div_start = 1'b0;
      mem_rd    = 1'b0;
      mul_x     = 1'b0;
      mul_m     = 1'b0;
      rnd       = 1'b0;
      rd_load   = 1'b0;
      fin_go    = 1'b0;
      case (state_ff)
         cmn_pkg::ST_IDLE: begin
            q_pop     = q_valid;
            mem_rd    = q_valid && q_item.active;
            div_start = q_valid && q_item.active && q_item.upd;
         end
         cmn_pkg::ST_READ:  rd_load = 1'b1;
         cmn_pkg::ST_MUL_X: mul_x   = 1'b1;
         cmn_pkg::ST_MUL_M: mul_m   = 1'b1;
         cmn_pkg::ST_ROUND: rnd     = 1'b1;
         cmn_pkg::ST_FIN:   fin_go  = !fin_stall;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cmn_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         item_ff <= q_item;
      end
   end

   // mean store, entries never written read as zero
   assign rd_addr  = cmn_pkg::MEAN_AW'(q_item.idx);
   assign wr_addr  = cmn_pkg::MEAN_AW'(item_ff.idx);
   assign mem_wr   = fin_go && item_ff.upd && item_ff.active;
   assign mean_cur = mean_rd_vld_ff ? mean_rd_ff : '0;

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mean_mem[wr_addr] <= mean_ff;
      end
      if (mem_rd) begin
         mean_rd_ff     <= mean_mem[rd_addr];
         mean_rd_vld_ff <= mean_vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_vld_ff <= '0;
      end else if (mem_wr) begin
         mean_vld_ff[wr_addr] <= 1'b1;
      end
   end

   // one shared multiplier: alpha*x, then (1-alpha)*mean
   always_comb begin
      if (mul_x) begin
         coef  = $signed({1'b0, alpha});
         mdata = $signed(item_ff.value);
      end else begin
         coef  = $signed({1'b0, cmn_pkg::ALPHA_ONE - alpha});
         mdata = $signed(mean_cur);
      end
   end

   assign prod    = coef * mdata;
   assign rnd_sum = acc_ff + cmn_pkg::ROUND_HALF;

   always_ff @(posedge clock) begin
      if (mul_x) begin
         acc_ff <= prod;
      end else if (mul_m) begin
         acc_ff <= acc_ff + prod;
      end
      if (rd_load) begin
         mean_ff <= mean_cur;
      end else if (rnd) begin
         mean_ff <= rnd_sum[cmn_pkg::VALUE_W+cmn_pkg::FRAC_W-1:cmn_pkg::FRAC_W];
      end
   end

   // subtract and saturate
   always_comb begin
      diff = {item_ff.value[cmn_pkg::VALUE_W-1], item_ff.value} -
             {mean_ff[cmn_pkg::VALUE_W-1], mean_ff};
      if (diff[cmn_pkg::VALUE_W] != diff[cmn_pkg::VALUE_W-1]) begin
         diff_sat = diff[cmn_pkg::VALUE_W] ? {1'b1, {(cmn_pkg::VALUE_W-1){1'b0}}}
                                           : {1'b0, {(cmn_pkg::VALUE_W-1){1'b1}}};
      end else begin
         diff_sat = diff[cmn_pkg::VALUE_W-1:0];
      end
      result = item_ff.active ? diff_sat : item_ff.value;
   end

   // frame time
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_time_ff <= cmn_pkg::START_RST;
      end else if (cfg.load_time) begin
         frame_time_ff <= cfg.start_time;
      end else if (fin_go && item_ff.upd && item_ff.last &&
                   frame_time_ff != cmn_pkg::TIME_LIMIT) begin
         frame_time_ff <= frame_time_ff + 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (fin_go && item_ff.emit) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_go && item_ff.emit) begin
         rsp_value <= result;
         rsp_idx   <= item_ff.idx;
         rsp_last  <= item_ff.last;
      end
   end

   assign rsp_tvalid        = rsp_tvalid_ff;
   assign status.busy       = state_ff != cmn_pkg::ST_IDLE;
   assign status.frame_time = frame_time_ff;

endmodule

`default_nettype wire

### hdl/cepstral_mean_normalizer_unit.sv
// top level of the cepstral mean normalizer: register port, front, back
`default_nettype none
`include "cepstral_mean_normalizer_unit_assert.svh"

// channel   dir  handshake                contents
// req_      in   tvalid/tready            tdata: index, coefficient; tuser: command;
//                                         tlast: last of frame
// rsp_      out  tvalid/tready            tdata: coefficient, index; tlast: last of frame
// csr_      in   psel/penable/pready      five 32-bit registers at 4-byte steps
//
// an updating beat in the back end waits for the 17-step serial reciprocal of
// the clamped frame time; a subtract-only beat reads the stored mean, a
// pass-through beat skips both; a two-entry queue lets the front keep taking beats
// synchronous active-high reset clears control, the mean store valid bits and
// the frame time; no clearing pass is needed
// a stalled result holds in the output register while the back end goes on
// with the next queued beat until it has a result of its own to deliver

module cepstral_mean_normalizer_unit (
   input  logic                               clock,
   input  logic                               reset,
   // input beats
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [cmn_pkg::TDATA_W-1:0]        req_tdata,   // coeff_index, value_in
   input  logic [cmn_pkg::CMD_W-1:0]          req_tuser,   // command
   input  logic                               req_tlast,
   // result beats
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [cmn_pkg::TDATA_W-1:0]        rsp_tdata,   // value_out, coeff_index_out
   output logic                               rsp_tlast,
   // register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [cmn_pkg::ADDR_W-1:0]         csr_paddr,
   input  logic [cmn_pkg::CSR_W-1:0]          csr_pwdata,
   output logic [cmn_pkg::CSR_W-1:0]          csr_prdata,
   output logic                               csr_pready
);

   // register file
   logic [cmn_pkg::DIM_W-1:0]   dim_ff;
   logic [cmn_pkg::DIM_W-1:0]   energy_ff;
   logic [cmn_pkg::TIME_W-1:0]  tmin_ff;
   logic [cmn_pkg::TIME_W-1:0]  tmax_ff;
   logic [cmn_pkg::TIME_W-1:0]  start_ff;
   cmn_pkg::cmn_reg_type        reg_sel;
   logic                        csr_wr;
   logic                        start_wr;

   // front to back
   logic                         q_valid;
   logic                         q_pop;
   cmn_pkg::cmn_item_type        q_item;
   cmn_pkg::cmn_back_cfg_type    back_cfg;
   cmn_pkg::cmn_back_status_type back_status;

   logic [cmn_pkg::VALUE_W-1:0]  rsp_value;
   logic [cmn_pkg::IDX_W-1:0]    rsp_idx;

   assign csr_pready = 1'b1;
   assign reg_sel    = cmn_pkg::cmn_reg_type'(csr_paddr[cmn_pkg::ADDR_W-1:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign start_wr   = csr_wr && (reg_sel == cmn_pkg::REG_START);

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff    <= cmn_pkg::DIM_RST;
         energy_ff <= cmn_pkg::ENERGY_RST;
         tmin_ff   <= cmn_pkg::TMIN_RST;
         tmax_ff   <= cmn_pkg::TMAX_RST;
         start_ff  <= cmn_pkg::START_RST;
      end else if (csr_wr) begin
         case (reg_sel)
            cmn_pkg::REG_DIM:    dim_ff    <= csr_pwdata[cmn_pkg::DIM_W-1:0];
            cmn_pkg::REG_ENERGY: energy_ff <= csr_pwdata[cmn_pkg::DIM_W-1:0];
            cmn_pkg::REG_TMIN:   tmin_ff   <= csr_pwdata[cmn_pkg::TIME_W-1:0];
            cmn_pkg::REG_TMAX:   tmax_ff   <= csr_pwdata[cmn_pkg::TIME_W-1:0];
            cmn_pkg::REG_START:  start_ff  <= csr_pwdata[cmn_pkg::TIME_W-1:0];
            default: ;
         endcase
      end
   end

   // read mux, energy index read back as its raw 6-bit field
   always_comb begin
      case (reg_sel)
         cmn_pkg::REG_DIM:    csr_prdata = cmn_pkg::CSR_W'(dim_ff);
         cmn_pkg::REG_ENERGY: csr_prdata = cmn_pkg::CSR_W'(energy_ff);
         cmn_pkg::REG_TMIN:   csr_prdata = cmn_pkg::CSR_W'(tmin_ff);
         cmn_pkg::REG_TMAX:   csr_prdata = cmn_pkg::CSR_W'(tmax_ff);
         cmn_pkg::REG_START:  csr_prdata = cmn_pkg::CSR_W'(start_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // writing the start time reloads the frame time at once
   assign back_cfg.time_min   = tmin_ff;
   assign back_cfg.time_max   = tmax_ff;
   assign back_cfg.load_time  = start_wr;
   assign back_cfg.start_time = csr_pwdata[cmn_pkg::TIME_W-1:0];

   // front: classify and queue
   cmn_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .cmd          (req_tuser),
      .idx          (req_tdata[cmn_pkg::IDX_W-1:0]),
      .value        (req_tdata[cmn_pkg::IDX_W+cmn_pkg::VALUE_W-1:cmn_pkg::IDX_W]),
      .last         (req_tlast),
      .dim_in_use   (dim_ff),
      .energy_index (energy_ff),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (q_pop)
   );

   // back: mean update, subtraction, result register
   cmn_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .cfg        (back_cfg),
      .status     (back_status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_value  (rsp_value),
      .rsp_idx    (rsp_idx),
      .rsp_last   (rsp_tlast)
   );

   // result packing: coefficient low, index above it, zero fill
   assign rsp_tdata = {{(cmn_pkg::TDATA_W-cmn_pkg::VALUE_W-cmn_pkg::IDX_W){1'b0}},
                       rsp_idx, rsp_value};

   // start time write lands in the frame time counter on the next cycle
   `CMN_ASSERT_NEXT(a_start_load, clock, reset, start_wr, back_status.frame_time == $past(csr_pwdata[15:0]))
   // frame time only moves up unless reloaded
   `CMN_ASSERT_NEXT(a_time_mono, clock, reset, !start_wr, back_status.frame_time >= $past(back_status.frame_time))
   // a result beat only appears after the back end worked on an item
   `CMN_ASSERT_SAME(a_rsp_source, clock, reset, $rose(rsp_tvalid), $past(back_status.busy))

endmodule

`default_nettype wire

### tb/sv/tb_cepstral_mean_normalizer_unit.sv
// testbench of the cepstral mean normalizer: directed table, random frames, scoreboard
module tb_cepstral_mean_normalizer_unit;
   import cmn_pkg::*;

   localparam int CLOCK_HALF   = 5;
   localparam int RESET_CYCLES = 11;
   // an updating beat waits for the serial reciprocal, two more may wait in the queue
   localparam int SETTLE_CYCLES = 100;
   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 400000;

   // one expected or observed result beat
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [IDX_W-1:0]   idx;
      logic               last;
   } coeff_result_t;

   // one row of the directed table; pinned rows carry a hand-derived value
   typedef struct packed {
      cmn_cmd_type        cmd;
      logic [IDX_W-1:0]   idx;
      logic [VALUE_W-1:0] value;
      logic               last;
      logic               pinned;
      logic [VALUE_W-1:0] want;
   } directed_row_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [TDATA_W-1:0]  req_tdata = '0;
   logic [CMD_W-1:0]    req_tuser = '0;
   logic                req_tlast = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [TDATA_W-1:0]  rsp_tdata;
   logic                rsp_tlast;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]   csr_paddr = '0;
   logic [CSR_W-1:0]    csr_pwdata = '0;
   logic [CSR_W-1:0]    csr_prdata;
   logic                csr_pready;

   // predictor copy of the registers and the running means
   logic [DIM_W-1:0]         cfg_dim = DIM_RST;
   logic signed [DIM_W-1:0]  cfg_energy = ENERGY_RST;
   logic [TIME_W-1:0]        cfg_tmin = TMIN_RST;
   logic [TIME_W-1:0]        cfg_tmax = TMAX_RST;
   logic [TIME_W-1:0]        frame_count = START_RST;
   int                       running_mean [MAX_DIM];

   coeff_result_t expected_coeffs [$];
   directed_row_t directed_rows [16];

   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  hold_go = 1'b0;
   int  hold_left = 0;
   int  sent_beats = 0;
   int  checked_results = 0;
   int  settings_used = 1;
   int  fail_count = 0;

   cepstral_mean_normalizer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),    // [4:0] coeff_index, [36:5] value_in, rest zero
      .req_tuser   (req_tuser),    // [1:0] command
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),    // [31:0] value_out, [36:32] coeff_index_out, rest zero
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #CLOCK_HALF clock = ~clock;

   // hard stop if the run hangs
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   // weight of the newest coefficient, unsigned q1.16, from the clamped frame time
   function automatic int unsigned update_weight();
      int unsigned d;
      if (frame_count < cfg_tmin) begin
         d = cfg_tmin;
      end else if (frame_count > cfg_tmax) begin
         d = cfg_tmax;
      end else begin
         d = frame_count;
      end
      // a zero clamped time means full weight on the new value
      if (d == 0) begin
         d = 1;
      end
      return (65536 + d / 2) / d;
   endfunction

   // advances the predicted means and frame time for one accepted beat;
   // returns 1 when the beat produces a result
   function automatic bit normalize_coeff(input cmn_cmd_type cmd, input logic [IDX_W-1:0] idx,
                                          input logic [VALUE_W-1:0] raw, input logic last,
                                          output coeff_result_t res);
      bit     upd;
      bit     emit;
      bit     active;
      longint x;
      longint a;
      longint p;
      longint y;
      upd    = (cmd == CMD_UPD_SUB) || (cmd == CMD_UPD);
      emit   = (cmd == CMD_UPD_SUB) || (cmd == CMD_SUB);
      // energy coefficient and indexes beyond the frame pass straight through
      active = (idx < cfg_dim) && (int'(idx) < MAX_DIM) && (int'(idx) != int'(cfg_energy));
      x      = longint'($signed(raw));
      y      = x;
      res    = '0;
      if (cmd == CMD_NOP) begin
         return 1'b0;
      end
      if (active) begin
         if (upd) begin
            a = longint'(update_weight());
            p = a * x + (65536 - a) * longint'(running_mean[idx]);
            // round half up, floor via arithmetic shift
            running_mean[idx] = int'((p + 32768) >>> 16);
         end
         y = x - longint'(running_mean[idx]);
         if (y > 64'sd2147483647) begin
            y = 64'sd2147483647;
         end
         if (y < -64'sd2147483648) begin
            y = -64'sd2147483648;
         end
      end
      if (upd && last && frame_count != TIME_LIMIT) begin
         frame_count = frame_count + 1'b1;
      end
      res.value = y[VALUE_W-1:0];
      res.idx   = idx;
      res.last  = last;
      return emit;
   endfunction

   // random coefficient: extremes, small q16.16 values near zero, or anything
   function automatic logic [VALUE_W-1:0] coeff_value();
      logic [19:0] small_val;
      small_val = 20'($urandom_range(20'hFFFFF));
      case ($urandom_range(9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3, 4, 5: return {{12{small_val[19]}}, small_val};
         default: return $urandom;
      endcase
   endfunction

   // two-phase register write; the register takes the value in the access cycle
   task automatic csr_write(input cmn_reg_type r, input logic [CSR_W-1:0] v);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {r, 2'b00};
      csr_pwdata  = v;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      case (r)
         REG_DIM:    cfg_dim = v[DIM_W-1:0];
         REG_ENERGY: cfg_energy = v[DIM_W-1:0];
         REG_TMIN:   cfg_tmin = v[TIME_W-1:0];
         REG_TMAX:   cfg_tmax = v[TIME_W-1:0];
         // writing the start time reloads the frame time at once
         REG_START:  frame_count = v[TIME_W-1:0];
         default: ;
      endcase
   endtask

   // offers one beat, holding it until taken; predicts at the accepting edge
   task automatic send_beat(input cmn_cmd_type cmd, input logic [IDX_W-1:0] idx,
                            input logic [VALUE_W-1:0] value, input logic last,
                            input logic pinned, input logic [VALUE_W-1:0] want);
      coeff_result_t res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {3'b000, value, idx};
      req_tuser  = cmd;
      req_tlast  = last;
      do @(posedge clock); while (!req_tready);
      if (normalize_coeff(cmd, idx, value, last, res)) begin
         if (pinned) begin
            res.value = want;
         end
         expected_coeffs.push_back(res);
      end
      sent_beats++;
      @(negedge clock);
   endtask

   // stop offering and wait until every predicted result has been seen
   task automatic wait_for_results();
      req_tvalid = 1'b0;
      while (expected_coeffs.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // the block may still be busy on beats that produce nothing
   task automatic settle_idle();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic apply_setting(input int dim, input int energy, input int tmin,
                                input int tmax, input int start);
      settle_idle();
      csr_write(REG_DIM, CSR_W'(dim));
      csr_write(REG_ENERGY, CSR_W'(energy & 6'h3F));
      csr_write(REG_TMIN, CSR_W'(tmin));
      csr_write(REG_TMAX, CSR_W'(tmax));
      csr_write(REG_START, CSR_W'(start));
      settings_used++;
   endtask

   // mostly whole frames with one command each, the rest loose beats of any kind
   task automatic run_random(input int n_items);
      int          count;
      int          pick;
      int          k;
      cmn_cmd_type fcmd;
      count = 0;
      while (count < n_items) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            if (pick < 50) begin
               fcmd = CMD_UPD_SUB;
            end else if (pick < 65) begin
               fcmd = CMD_SUB;
            end else begin
               fcmd = CMD_UPD;
            end
            for (k = 0; k < int'(cfg_dim); k++) begin
               send_beat(fcmd, k[IDX_W-1:0], coeff_value(), k == int'(cfg_dim) - 1, 1'b0, '0);
               count++;
            end
         end else begin
            repeat ($urandom_range(1, 4)) begin
               send_beat(cmn_cmd_type'($urandom_range(3)), IDX_W'($urandom_range(31)),
                         coeff_value(), 1'($urandom_range(1)), 1'b0, '0);
               count++;
            end
         end
      end
   endtask

   // result side: random stalls, or a long hold-off on request
   always @(negedge clock) begin
      if (hold_go) begin
         hold_left = HOLD_CYCLES;
         hold_go   = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_tready = 1'b0;
         hold_left--;
      end else begin
         rsp_tready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // scoreboard: each result beat against the oldest prediction
   always @(posedge clock) begin
      coeff_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_coeffs.size() == 0) begin
            $error("result beat with nothing expected: value_out %h", rsp_tdata[31:0]);
            fail_count++;
         end else begin
            want = expected_coeffs.pop_front();
            checked_results++;
            if (rsp_tdata[31:0] !== want.value) begin
               $error("value_out expected %h actual %h", want.value, rsp_tdata[31:0]);
               fail_count++;
            end
            if (rsp_tdata[36:32] !== want.idx) begin
               $error("coeff_index_out expected %0d actual %0d", want.idx, rsp_tdata[36:32]);
               fail_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_out expected %b actual %b", want.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   initial begin
      int i;
      for (i = 0; i < MAX_DIM; i++) begin
         running_mean[i] = 0;
      end
      // after reset the clamped time is 1, so the first update copies the value
      directed_rows = '{
         '{CMD_UPD_SUB, 5'd0,  32'h7FFF_FFFF, 1'b0, 1'b1, 32'h0},
         '{CMD_UPD_SUB, 5'd1,  32'h8000_0000, 1'b0, 1'b1, 32'h0},
         // max minus a most-negative mean saturates high
         '{CMD_SUB,     5'd1,  32'h7FFF_FFFF, 1'b0, 1'b1, 32'h7FFF_FFFF},
         // and the other way saturates low
         '{CMD_SUB,     5'd0,  32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000},
         '{CMD_UPD,     5'd2,  32'h1234_5678, 1'b0, 1'b0, 32'h0},
         '{CMD_SUB,     5'd2,  32'h1234_5678, 1'b0, 1'b1, 32'h0},
         // unused command: no result, no time step
         '{CMD_NOP,     5'd3,  32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0},
         '{CMD_SUB,     5'd12, 32'h0000_0005, 1'b1, 1'b1, 32'h0000_0005},
         // indexes beyond the frame pass through
         '{CMD_UPD_SUB, 5'd13, 32'hDEAD_BEEF, 1'b0, 1'b1, 32'hDEAD_BEEF},
         '{CMD_UPD_SUB, 5'd31, 32'h0001_0000, 1'b1, 1'b1, 32'h0001_0000},
         '{CMD_UPD_SUB, 5'd3,  32'h0003_0000, 1'b1, 1'b1, 32'h0},
         // frame time 2 now: half weight
         '{CMD_UPD_SUB, 5'd3,  32'h0007_0000, 1'b0, 1'b0, 32'h0},
         '{CMD_SUB,     5'd3,  32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
         '{CMD_UPD,     5'd4,  32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0},
         '{CMD_UPD_SUB, 5'd4,  32'h0000_0001, 1'b1, 1'b0, 32'h0},
         '{CMD_UPD_SUB, 5'd5,  32'h0000_0000, 1'b0, 1'b0, 32'h0}
      };

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table on the reset settings, no idling
      foreach (directed_rows[n]) begin
         send_beat(directed_rows[n].cmd, directed_rows[n].idx, directed_rows[n].value,
                   directed_rows[n].last, directed_rows[n].pinned, directed_rows[n].want);
      end

      // widest frame, energy at the first index, full time range
      apply_setting(32, 0, 1, 65535, 0);
      run_random(70);

      // one coefficient per frame, time clamps and counter at their top
      apply_setting(1, 31, 65535, 65535, 65535);
      send_idle_pct = 65;
      run_random(60);

      // zero lower clamp with a zero start time gives full weight
      apply_setting(16, -32, 0, 3, 0);
      send_idle_pct  = 0;
      recv_stall_pct = 65;
      run_random(70);

      // start time above the upper clamp, pause mid-phase until the block drains
      apply_setting(13, 5, 2, 50, 60);
      send_idle_pct  = 29;
      recv_stall_pct = 29;
      run_random(35);
      wait_for_results();
      run_random(35);

      // long result hold-off while beats keep coming, so the input stalls
      apply_setting(24, -1, 10, 10, 3);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_go = 1'b1;
      run_random(70);

      // frame time close to saturation, mixed idling
      apply_setting(32, 31, 1, 100, 65534);
      send_idle_pct  = 29;
      recv_stall_pct = 65;
      run_random(70);

      req_tvalid = 1'b0;
      wait_for_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (expected_coeffs.size() != 0) begin
         $error("%0d predicted results never arrived", expected_coeffs.size());
         fail_count++;
      end

      $display("run covered %0d input beats and %0d checked results", sent_beats,
               checked_results);
      $display("across %0d register settings with stalls on both sides", settings_used);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+hdl
hdl/cmn_pkg.sv
hdl/cmn_front.sv
hdl/cmn_recip.sv
hdl/cmn_back.sv
hdl/cepstral_mean_normalizer_unit.sv
tb/sv/tb_cepstral_mean_normalizer_unit.sv
